FILE: sv/ccwb_pkg.sv
// Shared types and constants for the color correction and white balance block.
// Used by ccwb_matrix, ccwb_balance and color_correction_white_balance_top.
// No dependencies.
package ccwb_pkg;

    // Width of one configuration register and of one packed 16-bit field in it.
    localparam int unsigned REG_W   = 48;
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned PIX_W   = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROW_BLUE  = 2'd0;
    localparam logic [1:0] REG_ROW_GREEN = 2'd1;
    localparam logic [1:0] REG_ROW_RED   = 2'd2;
    localparam logic [1:0] REG_GAINS     = 2'd3;

    // One 8-bit pixel in B, G, R order.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_bgr;

    // Three packed 16-bit fields: B in 15:0, G in 31:16, R in 47:32.
    typedef logic [REG_W-1:0] t_reg;

    // All three matrix rows, blue row at index 0.
    typedef t_reg [2:0] t_matrix;

endpackage

FILE: sv/ccwb_matrix.sv
// Matrix stages: nine coefficient products, then row sums with rounding and saturation.
// Depends on ccwb_pkg.
module ccwb_matrix #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ccwb_pkg::t_bgr   i_pix,
    input  ccwb_pkg::t_matrix i_coefs,
    output logic             o_valid,
    input  logic             i_ready,
    output ccwb_pkg::t_bgr   o_corr
);

    localparam int PROD_W = ccwb_pkg::FIELD_W + ccwb_pkg::PIX_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int unsigned HALF = 1 << (COEF_FRAC_BITS - 1);

    logic                           a_ready;
    logic                           b_ready;
    logic                           r_a_valid;
    logic                           r_b_valid;
    logic signed [PROD_W-1:0]       n_prod [3][3];
    logic signed [PROD_W-1:0]       r_prod [3][3];
    logic [ccwb_pkg::PIX_W-1:0]     n_corr [3];
    ccwb_pkg::t_bgr                 r_corr;
    logic signed [ccwb_pkg::PIX_W:0] px_s [3];

    // Each stage moves when it is empty or its successor takes its beat.
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Input channels zero-extended to signed for the signed multiplies.
    assign px_s[0] = signed'({1'b0, i_pix.blue});
    assign px_s[1] = signed'({1'b0, i_pix.green});
    assign px_s[2] = signed'({1'b0, i_pix.red});

    // Stage A: one product per coefficient.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = signed'(i_coefs[r][c*ccwb_pkg::FIELD_W +: ccwb_pkg::FIELD_W])
                             * px_s[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    // Stage B: row sums, round to nearest, clamp to 0..255.
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-1:0]        rnd;
        logic [SUM_W-1:0]        shf;
        for (int r = 0; r < 3; r++) begin
            sum = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2]);
            rnd = unsigned'(sum) + SUM_W'(HALF);
            shf = rnd >> COEF_FRAC_BITS;
            if (sum <= 0) begin
                n_corr[r] = '0;
            end else if (shf > SUM_W'(255)) begin
                n_corr[r] = '1;
            end else begin
                n_corr[r] = shf[ccwb_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_corr.blue  <= n_corr[0];
            r_corr.green <= n_corr[1];
            r_corr.red   <= n_corr[2];
        end
    end

    assign o_valid = r_b_valid;
    assign o_corr  = r_corr;

endmodule

FILE: sv/ccwb_balance.sv
// Balance stages: corrected channel times gain, then rounding and saturation.
// Depends on ccwb_pkg.
module ccwb_balance #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ccwb_pkg::t_bgr i_corr,
    input  ccwb_pkg::t_reg i_gains,
    output logic           o_valid,
    input  logic           i_ready,
    output ccwb_pkg::t_bgr o_corr,
    output ccwb_pkg::t_bgr o_bal
);

    localparam int PROD_W = ccwb_pkg::FIELD_W + ccwb_pkg::PIX_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int unsigned HALF = 1 << (COEF_FRAC_BITS - 1);

    logic                       c_ready;
    logic                       d_ready;
    logic                       r_c_valid;
    logic                       r_d_valid;
    logic [ccwb_pkg::PIX_W-1:0] ch [3];
    logic [PROD_W-1:0]          n_prod [3];
    logic [PROD_W-1:0]          r_prod [3];
    ccwb_pkg::t_bgr             r_c_corr;
    logic [ccwb_pkg::PIX_W-1:0] n_bal [3];
    ccwb_pkg::t_bgr             r_d_corr;
    ccwb_pkg::t_bgr             r_bal;

    // The output register frees as soon as the sink takes its beat.
    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    assign ch[0] = i_corr.blue;
    assign ch[1] = i_corr.green;
    assign ch[2] = i_corr.red;

    // Stage C: one gain product per channel.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = PROD_W'(ch[i]) * PROD_W'(i_gains[i*ccwb_pkg::FIELD_W +: ccwb_pkg::FIELD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && i_valid) begin
            r_prod   <= n_prod;
            r_c_corr <= i_corr;
        end
    end

    // Stage D: round to nearest and clamp at 255.
    always_comb begin
        logic [RND_W-1:0] rnd;
        logic [RND_W-1:0] shf;
        for (int i = 0; i < 3; i++) begin
            rnd = RND_W'(r_prod[i]) + RND_W'(HALF);
            shf = rnd >> COEF_FRAC_BITS;
            if (shf > RND_W'(255)) begin
                n_bal[i] = '1;
            end else begin
                n_bal[i] = shf[ccwb_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            r_d_corr    <= r_c_corr;
            r_bal.blue  <= n_bal[0];
            r_bal.green <= n_bal[1];
            r_bal.red   <= n_bal[2];
        end
    end

    assign o_valid = r_d_valid;
    assign o_corr  = r_d_corr;
    assign o_bal   = r_bal;

endmodule

FILE: sv/color_correction_white_balance_top.sv
// Top level of the color correction and white balance pipeline, with configuration registers.
// Depends on ccwb_pkg, ccwb_matrix and ccwb_balance.
//
// Takes one BGR pixel per clock while the output is not stalled and returns the pixel
// after a 3x3 signed color correction matrix (rounded, clamped to 0..255) together with
// that result scaled by per-channel white-balance gains (rounded, clamped again). The
// datapath is four register stages: matrix products, row sums, gain products, and the
// rounded output register; a new pixel can be taken every cycle while the output does
// not stall. Stalls on the output hold each stage in place; empty stages keep filling.
// Coefficients and gains are written through a plain write port and must only change
// while no pixel is in flight. All rows use the original input pixel.
module color_correction_white_balance_top #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pix_blue,
    input  logic [7:0]  i_pix_green,
    input  logic [7:0]  i_pix_red,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_corr_blue,
    output logic [7:0]  o_corr_green,
    output logic [7:0]  o_corr_red,
    output logic [7:0]  o_bal_blue,
    output logic [7:0]  o_bal_green,
    output logic [7:0]  o_bal_red
);

    localparam ccwb_pkg::t_reg ONE = ccwb_pkg::REG_W'(1) << COEF_FRAC_BITS;

    ccwb_pkg::t_reg    r_row_blue;
    ccwb_pkg::t_reg    r_row_green;
    ccwb_pkg::t_reg    r_row_red;
    ccwb_pkg::t_reg    r_gains;
    ccwb_pkg::t_matrix coefs;
    ccwb_pkg::t_bgr    pix;
    ccwb_pkg::t_bgr    mid_corr;
    ccwb_pkg::t_bgr    out_corr;
    ccwb_pkg::t_bgr    out_bal;
    logic              mid_valid;
    logic              mid_ready;

    // Configuration registers; reset gives the identity matrix and unity gains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_blue  <= ONE;
            r_row_green <= ONE << ccwb_pkg::FIELD_W;
            r_row_red   <= ONE << (2 * ccwb_pkg::FIELD_W);
            r_gains     <= ONE | (ONE << ccwb_pkg::FIELD_W) | (ONE << (2 * ccwb_pkg::FIELD_W));
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccwb_pkg::REG_ROW_BLUE:  r_row_blue  <= i_cfg_data;
                ccwb_pkg::REG_ROW_GREEN: r_row_green <= i_cfg_data;
                ccwb_pkg::REG_ROW_RED:   r_row_red   <= i_cfg_data;
                ccwb_pkg::REG_GAINS:     r_gains     <= i_cfg_data;
            endcase
        end
    end

    assign coefs[0] = r_row_blue;
    assign coefs[1] = r_row_green;
    assign coefs[2] = r_row_red;

    assign pix.blue  = i_pix_blue;
    assign pix.green = i_pix_green;
    assign pix.red   = i_pix_red;

    // Matrix half of the pipeline.
    ccwb_matrix #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (pix),
        .i_coefs (coefs),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_corr  (mid_corr)
    );

    // White-balance half of the pipeline.
    ccwb_balance #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_balance (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_corr  (mid_corr),
        .i_gains (r_gains),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_corr  (out_corr),
        .o_bal   (out_bal)
    );

    assign o_corr_blue  = out_corr.blue;
    assign o_corr_green = out_corr.green;
    assign o_corr_red   = out_corr.red;
    assign o_bal_blue   = out_bal.blue;
    assign o_bal_green  = out_bal.green;
    assign o_bal_red    = out_bal.red;

endmodule
